FILE: design/pfbt_pkg.sv
`default_nettype none

package pfbt_pkg;

    // Bitmap geometry (one busy bit per page)
    localparam int NUM_PAGES    = 65536;
    localparam int COUNTER_BITS = 32;
    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int MAP_WORDS    = NUM_PAGES / WORD_BITS;
    localparam int MAP_ADDR_W   = $clog2(MAP_WORDS);
    localparam int PAGE_W       = $clog2(NUM_PAGES);
    localparam int POP_W        = BIT_IDX_W + 1;

    // Field widths
    localparam int OP_W      = 3;
    localparam int FIRST_W   = 16;
    localparam int COUNT_W   = 17;
    localparam int END_W     = 18;
    localparam int CHANGED_W = 17;
    localparam int OUT_CNT_W = 32;
    localparam int TOTAL_W   = 17;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 120;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOCK      = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
    localparam logic [OP_W-1:0] OP_RESERVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd3;
    localparam logic [OP_W-1:0] OP_START     = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_RESP
    } state_t;

    // Adder-tree population count over one bitmap word
    function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [POP_W-1:0] s [WORD_BITS];
        for (int i = 0; i < WORD_BITS; i++) begin
            s[i] = POP_W'(w[i]);
        end
        for (int lvl = 0; lvl < BIT_IDX_W; lvl++) begin
            for (int i = 0; i < (WORD_BITS >> (lvl + 1)); i++) begin
                s[i] = s[2*i] + s[2*i+1];
            end
        end
        return s[0];
    endfunction

endpackage

`default_nettype wire

FILE: design/page_frame_bitmap_tracker_core.sv
`default_nettype none

// Page frame bitmap tracker: one busy bit per page plus free/used/reserved counters.
// Input beats carry an operation in s_axis_tuser and a page range in s_axis_tdata;
// each beat yields exactly one result beat on the m_axis channel.
// The bitmap lives in a RAM of 32-bit words; a range operation does a read and a
// modify/write of each word it touches in the in-bitmap part of the range.
// Start, zero-count and unused codes skip the word walk and go straight to result.
// One item is worked at a time; the next beat is accepted once the previous
// result has been handed to the output register.
// Reset: after aresetn falls and rises the RAM is swept to zero, one word per
// cycle over all 2048 words, with s_axis_tready low; cfg writes are taken meanwhile.
// Stall: a result waits in the output register while m_axis_tready is low; the
// next beat may be accepted and worked, and its result waits until the register is taken.
// total_pages is written through cfg_wr_en / cfg_wr_data only while idle; left to the user.
module page_frame_bitmap_tracker_core
    import pfbt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration: total_pages
    input  wire logic                cfg_wr_en,
    input  wire logic [TOTAL_W-1:0]  cfg_wr_data,
    // input channel
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // first_page[15:0], page_count[32:16]
    input  wire logic [OP_W-1:0]     s_axis_tuser,  // operation[2:0]
    // result channel
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [M_DATA_W-1:0]      m_axis_tdata   // pages_changed[16:0], free_pages[48:17],
                                                    // used_pages[80:49],
                                                    // reserved_pages[112:81],
                                                    // out_of_range[113]
);

    state_t                  state_reg, state_next;
    logic [MAP_ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic                    want_reg, want_next;
    logic [MAP_ADDR_W-1:0]   first_word_reg, first_word_next;
    logic [MAP_ADDR_W-1:0]   last_word_reg, last_word_next;
    logic [MAP_ADDR_W-1:0]   cur_word_reg, cur_word_next;
    logic [BIT_IDX_W-1:0]    first_bit_reg, first_bit_next;
    logic [BIT_IDX_W-1:0]    last_bit_reg, last_bit_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [CHANGED_W-1:0]    changed_reg, changed_next;
    logic                    oor_reg, oor_next;
    logic [COUNTER_BITS-1:0] free_reg, free_next;
    logic [COUNTER_BITS-1:0] used_reg, used_next;
    logic [COUNTER_BITS-1:0] rsv_reg, rsv_next;
    logic [TOTAL_W-1:0]      total_pages_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;

    logic [FIRST_W-1:0]      in_first;
    logic [COUNT_W-1:0]      in_count;
    logic [END_W-1:0]        first_ext, end_page, num_ext, lim_end, last_ext;
    logic                    in_range_op, in_oor, in_walk;

    logic [MAP_ADDR_W-1:0]   ram_addr;
    logic                    ram_we;
    logic [WORD_BITS-1:0]    ram_wdata, ram_rdata;
    logic [WORD_BITS-1:0]    mask, flip;
    logic [POP_W-1:0]        pop;
    logic [COUNTER_BITS-1:0] pop_ext;

    assign in_first = s_axis_tdata[FIRST_W-1:0];
    assign in_count = s_axis_tdata[FIRST_W +: COUNT_W];

    // Range decode of the incoming beat
    always_comb begin
        first_ext   = END_W'(in_first);
        end_page    = first_ext + END_W'(in_count);
        num_ext     = END_W'(NUM_PAGES);
        in_range_op = (s_axis_tuser == OP_LOCK) || (s_axis_tuser == OP_FREE) ||
                      (s_axis_tuser == OP_RESERVE) || (s_axis_tuser == OP_UNRESERVE);
        in_oor      = in_range_op && (in_count != '0) && (end_page > num_ext);
        lim_end     = (end_page > num_ext) ? num_ext : end_page;
        last_ext    = lim_end - END_W'(1);
        in_walk     = in_range_op && (in_count != '0) && (first_ext < num_ext);
    end

    // Pages of the current word that fall inside the range, and those to flip
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ((cur_word_reg != first_word_reg) ||
                       (BIT_IDX_W'(b) >= first_bit_reg)) &&
                      ((cur_word_reg != last_word_reg) ||
                       (BIT_IDX_W'(b) <= last_bit_reg));
        end
        flip    = mask & (want_reg ? ~ram_rdata : ram_rdata);
        pop     = popcount(flip);
        pop_ext = COUNTER_BITS'(pop);
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        op_next         = op_reg;
        want_next       = want_reg;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        cur_word_next   = cur_word_reg;
        first_bit_next  = first_bit_reg;
        last_bit_next   = last_bit_reg;
        count_next      = count_reg;
        changed_next    = changed_reg;
        oor_next        = oor_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        rsv_next        = rsv_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        s_axis_tready   = 1'b0;
        ram_addr        = cur_word_reg;
        ram_we          = 1'b0;
        ram_wdata       = ram_rdata ^ flip;

        // output register drains independently
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_addr      = clr_addr_reg;
                ram_we        = 1'b1;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + MAP_ADDR_W'(1);
                if (clr_addr_reg == MAP_ADDR_W'(MAP_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    op_next         = s_axis_tuser;
                    want_next       = (s_axis_tuser == OP_LOCK) ||
                                      (s_axis_tuser == OP_RESERVE);
                    first_word_next = first_ext[PAGE_W-1:BIT_IDX_W];
                    last_word_next  = last_ext[PAGE_W-1:BIT_IDX_W];
                    cur_word_next   = first_ext[PAGE_W-1:BIT_IDX_W];
                    first_bit_next  = first_ext[BIT_IDX_W-1:0];
                    last_bit_next   = last_ext[BIT_IDX_W-1:0];
                    count_next      = in_count;
                    changed_next    = '0;
                    oor_next        = in_oor;
                    if (s_axis_tuser == OP_START) begin
                        free_next = COUNTER_BITS'(total_pages_reg);
                    end
                    state_next = in_walk ? ST_READ : ST_RESP;
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                ram_we       = 1'b1;
                changed_next = changed_reg + CHANGED_W'(pop);
                free_next    = want_reg ? (free_reg - pop_ext) : (free_reg + pop_ext);
                case (op_reg)
                    OP_LOCK:      used_next = used_reg + pop_ext;
                    OP_FREE:      used_next = used_reg - pop_ext;
                    OP_RESERVE:   rsv_next  = rsv_reg + pop_ext;
                    OP_UNRESERVE: rsv_next  = rsv_reg - pop_ext;
                    default:      ;
                endcase
                if (cur_word_reg == last_word_reg) begin
                    state_next = ST_RESP;
                end else begin
                    cur_word_next = cur_word_reg + MAP_ADDR_W'(1);
                    state_next    = ST_READ;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, oor_reg, rsv_reg[OUT_CNT_W-1:0],
                                    used_reg[OUT_CNT_W-1:0], free_reg[OUT_CNT_W-1:0],
                                    changed_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            free_reg        <= '0;
            used_reg        <= '0;
            rsv_reg         <= '0;
            total_pages_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            free_reg     <= free_next;
            used_reg     <= used_next;
            rsv_reg      <= rsv_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                total_pages_reg <= cfg_wr_data;
            end
        end
    end

    // Per-item payload
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        want_reg       <= want_next;
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        cur_word_reg   <= cur_word_next;
        first_bit_reg  <= first_bit_next;
        last_bit_reg   <= last_bit_next;
        count_reg      <= count_next;
        changed_reg    <= changed_next;
        oor_reg        <= oor_next;
        m_data_reg     <= m_data_next;
    end

    pfbt_map_ram #(
        .ADDR_W (MAP_ADDR_W),
        .DATA_W (WORD_BITS)
    ) u_map_ram (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Bitmap is written only by the sweep or by a modify step
    a_ram_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_MODIFY || state_reg == ST_CLEAR))
        else $error("bitmap written outside sweep or modify");

    // Walk stays inside the requested word span
    a_walk_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODIFY) |->
            (cur_word_reg >= first_word_reg && cur_word_reg <= last_word_reg))
        else $error("word walk left the range");

    // Never more changed pages than requested
    a_changed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP) |-> (changed_reg <= count_reg))
        else $error("pages_changed exceeds page_count");

    // Start touches nothing but the free counter
    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && op_reg == OP_START) |-> (changed_reg == '0 && !oor_reg))
        else $error("start reported changed or out-of-range pages");

    // Modify step follows a read of the same word
    a_read_before_modify: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODIFY) |-> ($past(state_reg) == ST_READ && $stable(cur_word_reg)))
        else $error("modify without preceding read");

endmodule

`default_nettype wire

FILE: design/pfbt_map_ram.sv
`default_nettype none

// Single-port synchronous RAM, registered read data
module pfbt_map_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic              we,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: tb/page_frame_bitmap_tracker_core_tb.sv
module page_frame_bitmap_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfbt_pkg::*;

    // Spare operation codes: the block must leave all state alone
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int N_DIRECTED   = 20;
    localparam int PHASE_ITEMS  = 225;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT      = 350;
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 40;

    // One result beat, fields in tdata order
    typedef struct packed {
        logic [CHANGED_W-1:0] changed;
        logic [OUT_CNT_W-1:0] free_pg;
        logic [OUT_CNT_W-1:0] used_pg;
        logic [OUT_CNT_W-1:0] rsvd_pg;
        logic                 oor;
    } page_result_t;

    // One directed row; want is only used when known is set
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIRST_W-1:0] first;
        logic [COUNT_W-1:0] count;
        logic               known;
        page_result_t       want;
    } stim_row_t;

    localparam page_result_t NO_RES = '0;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [TOTAL_W-1:0]  cfg_wr_data   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // Shadow of the tracker state
    bit                      busy_map [NUM_PAGES];
    logic [COUNTER_BITS-1:0] free_cnt  = '0;
    logic [COUNTER_BITS-1:0] used_cnt  = '0;
    logic [COUNTER_BITS-1:0] rsvd_cnt  = '0;
    logic [TOTAL_W-1:0]      total_pages_reg = '0;

    page_result_t pending_results [$];
    int unsigned  fail_count    = 0;
    int unsigned  results_taken = 0;
    int unsigned  items_sent    = 0;
    int unsigned  stall_cycles  = 0;

    // Directed rows: after reset, extremes, every operation and the corner cases
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_SPARE7,    16'd0,     17'd0,     1'b1, '{17'd0, 32'd0, 32'd0, 32'd0, 1'b0}},
        '{OP_START,     16'd0,     17'd0,     1'b1, '{17'd0, 32'd65536, 32'd0, 32'd0, 1'b0}},
        '{OP_LOCK,      16'd0,     17'd0,     1'b1, '{17'd0, 32'd65536, 32'd0, 32'd0, 1'b0}},
        '{OP_LOCK,      16'd0,     17'd1,     1'b1, '{17'd1, 32'd65535, 32'd1, 32'd0, 1'b0}},
        '{OP_LOCK,      16'd0,     17'd1,     1'b1, '{17'd0, 32'd65535, 32'd1, 32'd0, 1'b0}},
        '{OP_LOCK,      16'd65535, 17'd2,     1'b1, '{17'd1, 32'd65534, 32'd2, 32'd0, 1'b1}},
        '{OP_RESERVE,   16'd100,   17'd40,    1'b0, NO_RES},
        '{OP_FREE,      16'd90,    17'd60,    1'b0, NO_RES},
        '{OP_UNRESERVE, 16'd0,     17'd1,     1'b0, NO_RES},
        '{OP_UNRESERVE, 16'd65535, 17'd65536, 1'b0, NO_RES},
        '{OP_LOCK,      16'd0,     17'd65536, 1'b0, NO_RES},
        '{OP_LOCK,      16'd1,     17'd65535, 1'b0, NO_RES},
        '{OP_FREE,      16'd0,     17'd65536, 1'b0, NO_RES},
        '{OP_RESERVE,   16'hFFFF,  17'd65536, 1'b0, NO_RES},
        '{OP_UNRESERVE, 16'h5555,  17'h0AAAA, 1'b0, NO_RES},
        '{OP_SPARE5,    16'hFFFF,  17'h10000, 1'b0, NO_RES},
        '{OP_SPARE6,    16'hAAAA,  17'h0FFFF, 1'b0, NO_RES},
        '{OP_START,     16'd0,     17'd0,     1'b0, NO_RES},
        '{OP_FREE,      16'd65535, 17'd1,     1'b0, NO_RES},
        '{OP_LOCK,      16'h8000,  17'd64,    1'b0, NO_RES}
    };

    page_frame_bitmap_tracker_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the shadow bitmap and counters
    function automatic page_result_t apply_page_op(input logic [OP_W-1:0] op,
                                                   input logic [FIRST_W-1:0] first,
                                                   input logic [COUNT_W-1:0] count);
        page_result_t r;
        logic         want;
        int unsigned  page;
        r = '0;
        if (op == OP_START) begin
            free_cnt = COUNTER_BITS'(total_pages_reg);
        end else if (op <= OP_UNRESERVE) begin
            want = (op == OP_LOCK) || (op == OP_RESERVE);
            for (int unsigned i = 0; i < count; i++) begin
                page = first + i;
                if (page >= NUM_PAGES) begin
                    r.oor = 1'b1;
                end else if (busy_map[page] != want) begin
                    busy_map[page] = want;
                    r.changed++;
                    free_cnt = want ? free_cnt - 1'b1 : free_cnt + 1'b1;
                    case (op)
                        OP_LOCK:    used_cnt = used_cnt + 1'b1;
                        OP_FREE:    used_cnt = used_cnt - 1'b1;
                        OP_RESERVE: rsvd_cnt = rsvd_cnt + 1'b1;
                        default:    rsvd_cnt = rsvd_cnt - 1'b1;
                    endcase
                end
            end
        end
        r.free_pg = OUT_CNT_W'(free_cnt);
        r.used_pg = OUT_CNT_W'(used_cnt);
        r.rsvd_pg = OUT_CNT_W'(rsvd_cnt);
        return r;
    endfunction

    // Idle draw with bursts of back-to-back beats
    function automatic int draw_gap(input int unsigned idx);
        return (idx % 100 < 25) ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic write_total_pages(input logic [TOTAL_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        total_pages_reg = value;
    endtask

    // Offer one beat; valid stays high after accept so a zero gap runs back to back
    task automatic send_item(input logic [OP_W-1:0] op, input logic [FIRST_W-1:0] first,
                             input logic [COUNT_W-1:0] count, input logic known,
                             input page_result_t typed);
        page_result_t r;
        int           gap;
        gap = draw_gap(items_sent);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= S_DATA_W'({count, first});
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        r = apply_page_op(op, first, count);
        pending_results.push_back(known ? typed : r);
        items_sent++;
    endtask

    // Mostly small ranges in a busy window, some near the top of the map, a few huge
    task automatic send_random_item();
        logic [OP_W-1:0]    op;
        logic [FIRST_W-1:0] first;
        logic [COUNT_W-1:0] count;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)      op = OP_START;
        else if (pick < 7) op = OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
        else               op = OP_W'($urandom_range(OP_LOCK, OP_UNRESERVE));
        pick = $urandom_range(0, 99);
        if (pick < 60)      first = FIRST_W'($urandom_range(0, 1023));
        else if (pick < 80) first = FIRST_W'($urandom_range(65000, 65535));
        else                first = FIRST_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 3)       count = '0;
        else if (pick < 85) count = COUNT_W'($urandom_range(1, 48));
        else if (pick < 95) count = COUNT_W'($urandom_range(1, 2048));
        else if (pick < 98) count = COUNT_W'($urandom_range(0, 65535));
        else                count = COUNT_W'(NUM_PAGES);
        send_item(op, first, count, 1'b0, NO_RES);
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        logic [TOTAL_W-1:0] phase_total [4];
        phase_total[0] = '0;
        phase_total[1] = TOTAL_W'(1);
        phase_total[2] = TOTAL_W'($urandom_range(2, 65535));
        phase_total[3] = TOTAL_W'(NUM_PAGES);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        write_total_pages(TOTAL_W'(NUM_PAGES));

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(directed_rows[i].op, directed_rows[i].first, directed_rows[i].count,
                      directed_rows[i].known, directed_rows[i].want);
        end

        // Random phases, register changed only once the block has drained
        for (int p = 0; p < 4; p++) begin
            s_axis_tvalid <= 1'b0;
            wait_all_results();
            write_total_pages(phase_total[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
        end

        s_axis_tvalid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: random stalls plus one long hold-off to back up the input
    initial begin
        page_result_t got;
        page_result_t exp_res;
        int           gap;
        wait (aresetn);
        forever begin
            gap = (results_taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(results_taken + 37);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            got.changed = m_axis_tdata[16:0];
            got.free_pg = m_axis_tdata[48:17];
            got.used_pg = m_axis_tdata[80:49];
            got.rsvd_pg = m_axis_tdata[112:81];
            got.oor     = m_axis_tdata[113];
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result beat %0d arrived with nothing expected", results_taken);
            end else begin
                exp_res = pending_results.pop_front();
                if (got.changed !== exp_res.changed || got.free_pg !== exp_res.free_pg ||
                    got.used_pg !== exp_res.used_pg || got.rsvd_pg !== exp_res.rsvd_pg ||
                    got.oor !== exp_res.oor) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch on beat %0d (exp/got): changed %0d/%0d",
                                  " free %0d/%0d used %0d/%0d rsvd %0d/%0d oor %0b/%0b"},
                                 results_taken, exp_res.changed, got.changed,
                                 exp_res.free_pg, got.free_pg, exp_res.used_pg, got.used_pg,
                                 exp_res.rsvd_pg, got.rsvd_pg, exp_res.oor, got.oor);
                end
            end
            results_taken++;
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: files.f
design/pfbt_pkg.sv
design/pfbt_map_ram.sv
design/page_frame_bitmap_tracker_core.sv
tb/page_frame_bitmap_tracker_core_tb.sv
